@@ hw/rtl/dwc_pkg.sv @@
// Shared types and constants for the depthwise-convolution MAC and requantize block.
// No dependencies.
`default_nettype none

package dwc_pkg;

	localparam int ACC_W       = 32;
	localparam int ACT_W       = 8;
	localparam int SHIFT_W     = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_OFFSET = 2'd3;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [ACT_W-1:0] byte_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/dwc_mac.sv @@
// Front part: accepts window taps, runs the bias-seeded 32-bit accumulator and
// pushes each closed window's sum toward the requantizer. Depends on dwc_pkg.
`default_nettype none

module dwc_mac
	import dwc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  tap_valid,
	input  wire logic  full,
	input  wire byte_t activation,
	input  wire byte_t weight,
	input  wire logic  last_tap,
	input  wire acc_t  bias,
	output logic       push,
	output acc_t       push_data
);

	logic        window_open_q;
	acc_t        acc_q;
	acc_t        base;
	logic signed [2*ACT_W-1:0] product;
	acc_t        sum;
	logic        take;

	assign take      = tap_valid && !full;
	assign base      = window_open_q ? acc_q : bias;
	assign product   = activation * weight;
	assign sum       = base + ACC_W'(product);
	assign push      = take && last_tap;
	assign push_data = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q <= 1'b0;
			acc_q         <= '0;
		end else if (take) begin
			window_open_q <= !last_tap;
			acc_q         <= sum;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dwc_fifo.sv @@
// Short queue of accumulator sums between the MAC front and the requantize back.
// Depends on dwc_pkg.
`default_nettype none

module dwc_fifo
	import dwc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire acc_t  push_data,
	input  wire logic  pop,
	output acc_t       head,
	output fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	acc_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign push_ok    = push && !stat.full;
	assign pop_ok     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop_ok)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push_ok && !pop_ok)
				count_q <= count_q + 1'b1;
			else if (pop_ok && !push_ok)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.empty || stat.full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/dwc_requant.sv @@
// Back part: multiplies a window sum by the requantization multiplier, applies the
// rounding right shift, adds the zero point and saturates to int8. Depends on dwc_pkg.
`default_nettype none

module dwc_requant
	import dwc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fifo_stat_t         stat,
	input  wire acc_t               head,
	output logic                    pop,
	input  wire acc_t               multiplier,
	input  wire logic [SHIFT_W-1:0] shift,
	input  wire byte_t              zp_offset,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output byte_t                   result_value
);

	localparam logic signed [ACC_W+1:0] SAT_HI = (ACC_W+2)'(127);
	localparam logic signed [ACC_W+1:0] SAT_LO = -(ACC_W+2)'(128);

	logic                         v_s1, v_s2, v_s3;
	acc_t                         acc_s1;
	logic signed [2*ACC_W-1:0]    p_s2;
	logic signed [ACC_W:0]        r_s3;
	logic                         result_valid_q;
	byte_t                        result_q;

	logic                         adv_out, en_s3, en_s2, en_s1;
	acc_t                         hi;
	logic signed [ACC_W:0]        hi_x;
	logic signed [ACC_W:0]        shifted;
	logic                         rbit;
	logic signed [ACC_W:0]        rounded;
	logic signed [ACC_W+1:0]      with_zp;
	byte_t                        sat;

	assign adv_out = !result_valid_q || !result_stall;
	assign en_s3   = !v_s3 || adv_out;
	assign en_s2   = !v_s2 || en_s3;
	assign en_s1   = !v_s1 || en_s2;
	assign pop     = !stat.empty && en_s1;

	assign hi      = p_s2[2*ACC_W-1:ACC_W];
	assign hi_x    = {hi[ACC_W-1], hi};
	assign shifted = hi_x >>> shift;
	assign rbit    = (shift != '0) ? hi[shift - 1'b1] : 1'b0;
	assign rounded = shifted + $signed({{ACC_W{1'b0}}, rbit});

	assign with_zp = {r_s3[ACC_W], r_s3} + (ACC_W+2)'(zp_offset);
	always_comb begin
		if (with_zp > SAT_HI)
			sat = 8'sd127;
		else if (with_zp < SAT_LO)
			sat = -8'sd128;
		else
			sat = with_zp[ACT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en_s1)   v_s1           <= pop;
			if (en_s2)   v_s2           <= v_s1;
			if (en_s3)   v_s3           <= v_s2;
			if (adv_out) result_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pop)  acc_s1   <= head;
		if (en_s2 && v_s1) p_s2     <= acc_s1 * multiplier;
		if (en_s3 && v_s2) r_s3     <= rounded;
		if (adv_out && v_s3) result_q <= sat;
	end

	assign result_valid = result_valid_q;
	assign result_value = result_q;

`ifndef SYNTHESIS
	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped request not captured");
	a_out_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv_out) |=> result_valid_q)
		else $error("finished request not presented");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s3) |=> (v_s2 && $stable(p_s2)))
		else $error("blocked product stage changed");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/depthwise_conv_mac_requantize_int8.sv @@
// Throughput: one tap per cycle; the MAC front stalls only while the queue is full.
// Path: after the edge that accepts a last tap, a window sum passes through the queue
// write, operand, 32x32 product, rounding shift, and zero point and clamp registers.
// A queue of QUEUE_DEPTH window sums lets the MAC run on while results wait.
// Reset (arst_n low, asynchronous): config registers zero, no window open, queue and
// pipeline empty.
`default_nettype none

module depthwise_conv_mac_requantize_int8
	import dwc_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tap_valid,
	output logic                      tap_stall,
	input  wire byte_t                activation,
	input  wire byte_t                weight,
	input  wire logic                 last_tap,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output byte_t                     result_value,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ACC_W-1:0]     cfg_data
);

	acc_t               bias_q;
	acc_t               mult_q;
	logic [SHIFT_W-1:0] shift_q;
	byte_t              zp_q;

	logic       push;
	acc_t       push_data;
	logic       pop;
	acc_t       head;
	fifo_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			mult_q  <= '0;
			shift_q <= '0;
			zp_q    <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_BIAS:       bias_q  <= cfg_data;
				CFG_MULTIPLIER: mult_q  <= cfg_data;
				CFG_SHIFT:      shift_q <= cfg_data[SHIFT_W-1:0];
				CFG_OUT_OFFSET: zp_q    <= cfg_data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	assign tap_stall = stat.full;

	dwc_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.tap_valid  (tap_valid),
		.full       (stat.full),
		.activation (activation),
		.weight     (weight),
		.last_tap   (last_tap),
		.bias       (bias_q),
		.push       (push),
		.push_data  (push_data)
	);

	dwc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	dwc_requant u_requant (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.head         (head),
		.pop          (pop),
		.multiplier   (mult_q),
		.shift        (shift_q),
		.zp_offset    (zp_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_value (result_value)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench for depthwise_conv_mac_requantize_int8: streams window taps, predicts each
// requantized int8 pixel and checks results in order under random gaps and stalls.
// Depends on dwc_pkg and the depthwise_conv_mac_requantize_int8 RTL.

module tb;
	import dwc_pkg::*;

	typedef struct {
		byte_t activation;
		byte_t weight;
		logic  last;
	} tap_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 tap_valid = 1'b0;
	logic                 tap_stall;
	byte_t                activation = '0;
	byte_t                weight = '0;
	logic                 last_tap = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	byte_t                result_value;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BIAS;
	logic [ACC_W-1:0]     cfg_data = '0;

	tap_t  taps_pending[$];
	byte_t pixels_due[$];

	acc_t               bias_reg = '0;
	acc_t               mult_reg = '0;
	logic [SHIFT_W-1:0] shift_reg = '0;
	byte_t              zp_reg = '0;
	acc_t               window_sum = '0;
	logic               window_busy = 1'b0;

	bit src_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	int fault_count = 0;
	int pixel_count = 0;

	depthwise_conv_mac_requantize_int8 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tap_valid    (tap_valid),
		.tap_stall    (tap_stall),
		.activation   (activation),
		.weight       (weight),
		.last_tap     (last_tap),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_value (result_value),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic byte_t requantize_sum(acc_t sum);
		logic signed [63:0] prod;
		logic signed [39:0] val;
		prod = sum * mult_reg;
		val = 40'($signed(prod[63:32]));
		if (shift_reg != 0)
			val = (val >>> shift_reg) + ((val >>> (shift_reg - 1)) & 40'sd1);
		val = val + zp_reg;
		if (val > 127)
			return 8'sd127;
		if (val < -128)
			return 8'sh80;
		return byte_t'(val[7:0]);
	endfunction

	function automatic void predict_tap(byte_t a, byte_t w, logic last);
		logic signed [15:0] prod;
		prod = a * w;
		if (!window_busy)
			window_sum = bias_reg;
		window_sum = window_sum + prod;
		if (last) begin
			window_busy = 1'b0;
			pixels_due.push_back(requantize_sum(window_sum));
		end else begin
			window_busy = 1'b1;
		end
	endfunction

	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic byte_t pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'sh80;
		if (r == 1)
			return 8'sd127;
		return byte_t'($urandom);
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void add_tap(byte_t a, byte_t w, logic last);
		tap_t t;
		t.activation = a;
		t.weight = w;
		t.last = last;
		taps_pending.push_back(t);
	endfunction

	function automatic void add_window(int len);
		for (int i = 0; i < len; i++)
			add_tap(pick_byte(), pick_byte(), i == len - 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin : tap_driver
		tap_t nxt;
		int   idle_left;
		if (!arst_n) begin
			tap_valid <= 1'b0;
			activation <= '0;
			weight <= '0;
			last_tap <= 1'b0;
			idle_left = 0;
		end else begin
			if (tap_valid && !tap_stall)
				predict_tap(activation, weight, last_tap);
			if (!tap_valid || !tap_stall) begin
				if (idle_left == 0 && taps_pending.size() != 0) begin
					nxt = taps_pending.pop_front();
					tap_valid <= 1'b1;
					activation <= nxt.activation;
					weight <= nxt.weight;
					last_tap <= nxt.last;
					idle_left = pick_gap(src_gaps);
				end else begin
					tap_valid <= 1'b0;
					if (idle_left != 0)
						idle_left--;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		byte_t want;
		int    stall_left;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pixels_due.size() == 0) begin
					note_fault($sformatf("result %0d: unexpected value %0d",
						pixel_count, result_value));
				end else begin
					want = pixels_due.pop_front();
					if (result_value !== want)
						note_fault($sformatf("result %0d: expected %0d, got %0d",
							pixel_count, want, result_value));
				end
				pixel_count++;
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				stall_left = pick_gap(sink_stalls);
			end
		end
	end

	task automatic write_regs(acc_t bias, acc_t mult, logic [SHIFT_W-1:0] sh, byte_t zp);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_BIAS;
		cfg_data <= bias;
		@(posedge clk);
		cfg_index <= CFG_MULTIPLIER;
		cfg_data <= mult;
		@(posedge clk);
		cfg_index <= CFG_SHIFT;
		cfg_data <= {{(ACC_W - SHIFT_W){1'b0}}, sh};
		@(posedge clk);
		cfg_index <= CFG_OUT_OFFSET;
		cfg_data <= {{(ACC_W - ACT_W){1'b0}}, zp};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		bias_reg = bias;
		mult_reg = mult;
		shift_reg = sh;
		zp_reg = zp;
		@(negedge clk);
	endtask

	// hold until every request is taken and every pixel is back (or the wait limit runs out), then let the pipe drain
	task automatic settle();
		int waited;
		waited = 0;
		while ((taps_pending.size() != 0 || tap_valid || pixels_due.size() != 0)
			&& waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (12) @(negedge clk);
	endtask

	initial begin : stimulus
		int   count;
		int   len;
		int   r;
		acc_t bias;
		acc_t mult;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_regs(32'sh7FFF_FFF0, 32'sh4000_0000, 5'd0, 8'sd0);
		add_tap(8'sd127, 8'sd127, 1'b0);
		add_tap(8'sd127, 8'sd127, 1'b1);
		add_tap(8'sh80, 8'sh80, 1'b1);
		add_tap(8'sd0, 8'sd0, 1'b1);
		add_tap(8'sh80, 8'sd127, 1'b1);
		settle();

		write_regs(32'sh8000_0000, 32'sh8000_0000, 5'd31, 8'sd127);
		add_tap(8'sd0, 8'sd0, 1'b1);
		add_tap(8'sd1, -8'sd1, 1'b0);
		add_tap(8'sd127, 8'sh80, 1'b1);
		settle();

		write_regs(32'sd3, 32'sh1000_0000, 5'd1, 8'sh80);
		add_tap(8'sd1, 8'sd13, 1'b1);
		add_tap(-8'sd1, 8'sd19, 1'b1);
		add_tap(8'sd2, 8'sd6, 1'b0);
		add_tap(8'sd1, 8'sd1, 1'b1);
		add_tap(-8'sd1, -8'sd1, 1'b1);
		settle();

		write_regs(32'sd0, 32'sh7FFF_FFFF, 5'd4, 8'sd0);
		add_tap(8'sd100, -8'sd100, 1'b0);
		add_tap(8'sd55, -8'sd3, 1'b1);
		add_tap(8'sh80, 8'sh80, 1'b0);
		add_tap(8'sh80, 8'sh80, 1'b0);
		add_tap(8'sh80, 8'sh80, 1'b0);
		add_tap(8'sd127, 8'sd127, 1'b1);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			src_gaps = (ph % 4 != 1);
			sink_stalls = (ph % 4 != 2);
			if (ph % 3 == 2) begin
				write_regs(acc_t'($urandom), acc_t'($urandom), 5'($urandom_range(0, 31)),
					byte_t'($urandom));
			end else begin
				bias = $urandom_range(0, 10000) - 5000;
				mult = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
				if ($urandom_range(0, 1))
					mult = -mult;
				write_regs(bias, mult, 5'($urandom_range(0, 12)), byte_t'($urandom));
			end
			count = 0;
			while (count < 50) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 6);
				else if (r < 95)
					len = $urandom_range(7, 16);
				else
					len = $urandom_range(17, 40);
				add_window(len);
				count += len;
			end
			settle();
		end

		if (pixels_due.size() != 0)
			note_fault($sformatf("%0d expected pixels never arrived", pixels_due.size()));
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
